// ----- rtl/core/ambient_light_lux_calc_unit_assert.svh -----
// Assertion macros for the ambient light lux unit.
// Bodies assume the including module has aclk and aresetn in scope.
`ifndef AMBIENT_LIGHT_LUX_CALC_UNIT_ASSERT_SVH
`define AMBIENT_LIGHT_LUX_CALC_UNIT_ASSERT_SVH

// same-cycle implication
`define ALC_CHK_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("lux unit check failed");

// next-cycle implication
`define ALC_CHK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("lux unit check failed");

`endif

// ----- rtl/core/alc_pkg.sv -----
// Shared types, constants and coefficient tables for the lux unit.
// No dependencies.
`timescale 1ns / 1ps

package alc_pkg;

    localparam int ALC_POW_ENTRIES = 64;
    localparam int ALC_RATIO_FRAC  = 16;

    localparam int CNT_W     = 16;
    localparam int LUX_W     = 28;
    localparam int STS_W     = 2;
    localparam int PKG_W     = 4;
    localparam int SEG_W     = 3;
    localparam int COEF_W    = 13;
    localparam int BRK_W     = 8;
    localparam int POW_W     = 16;
    localparam int Q_FRAC    = 16;
    localparam int PROD_W    = 48;
    localparam int MUL_A_W   = 32;
    localparam int POS_W     = 44;
    localparam int NEG_W     = 45;
    localparam int DIV_REM_W = 17;
    localparam int DIV_SH_W  = LUX_W;
    localparam int DIV_CNT_W = 5;

    localparam logic [DIV_REM_W-1:0] COEF_SCALE = DIV_REM_W'(100000);

    // lux scale by 1e5: drop 5 low bits, then divide by 3125 in 13-bit chunks
    localparam int SCL_PRE     = 5;
    localparam int SCL_CHUNK_W = 13;
    localparam int SCL_STEPS   = 3;
    localparam int SCL_NUM_W   = SCL_CHUNK_W * SCL_STEPS;
    localparam int SCL_REM_W   = 12;
    localparam int SCL_X_W     = SCL_REM_W + SCL_CHUNK_W;
    localparam int SCL_RECIP_W = 26;
    localparam int SCL_PROD_W  = SCL_X_W + SCL_RECIP_W;
    localparam int SCL_SHIFT   = 37;
    localparam int SCL_CNT_W   = 2;
    localparam logic [SCL_REM_W-1:0]   SCL_DIVISOR = 12'd3125;
    // ceil(2^37 / 3125); exact quotient for any chunk value below 2^25
    localparam logic [SCL_RECIP_W-1:0] SCL_RECIP   = 26'd43980466;

    // package code values
    localparam logic [PKG_W-1:0] PKG_CS_A = 4'd0;
    localparam logic [PKG_W-1:0] PKG_CS_B = 4'd1;
    localparam logic [PKG_W-1:0] PKG_LD_A = 4'd4;
    localparam logic [PKG_W-1:0] PKG_LD_B = 4'd5;
    localparam logic [PKG_W-1:0] PKG_RESET = PKG_CS_B;

    // result status codes
    localparam logic [STS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STS_W-1:0] ST_ZERO   = 2'd1;
    localparam logic [STS_W-1:0] ST_BADPKG = 2'd2;

    // kinds of result written to the output register
    localparam logic [1:0] OUT_CALC = 2'd0;
    localparam logic [1:0] OUT_ZERO = 2'd1;
    localparam logic [1:0] OUT_HOLD = 2'd2;

    // multiplier operand selects
    localparam logic [1:0] MUL_KA_CH0  = 2'd0;
    localparam logic [1:0] MUL_KB_CH0  = 2'd1;
    localparam logic [1:0] MUL_KB_CH1  = 2'd2;
    localparam logic [1:0] MUL_PROD_PW = 2'd3;

    typedef struct packed {
        logic       load;
        logic       classify;
        logic       mul_en;
        logic [1:0] mul_sel;
        logic       pos_cap;
        logic       neg_cap;
        logic       neg_lin;
        logic       div_ratio;
        logic       div_lux;
        logic       idx_cap;
        logic       tab_cap;
        logic       out_load;
        logic [1:0] out_kind;
    } alc_cmd_t;

    typedef struct packed {
        logic ch0_zero;
        logic pkg_bad;
        logic seg_zero;
        logic div_busy;
    } alc_sts_t;

    // breakpoints in hundredths of ratio
    function automatic logic [BRK_W-1:0] brk_val(input logic leaded, input int unsigned s);
        logic [BRK_W-1:0] v;
        case (s)
            0:       v = leaded ? 8'd50 : 8'd52;
            1:       v = leaded ? 8'd61 : 8'd65;
            2:       v = 8'd80;
            default: v = 8'd130;
        endcase
        return v;
    endfunction

    // ch0 coefficient, 1e-5 units; segment above the last breakpoint gives zero
    function automatic logic [COEF_W-1:0] coef_a(input logic leaded, input logic [SEG_W-1:0] s);
        logic [COEF_W-1:0] v;
        case (s)
            3'd0:    v = leaded ? 13'd3040 : 13'd3150;
            3'd1:    v = leaded ? 13'd2240 : 13'd2290;
            3'd2:    v = leaded ? 13'd1280 : 13'd1570;
            3'd3:    v = leaded ? 13'd146  : 13'd338;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [COEF_W-1:0] coef_b(input logic leaded, input logic [SEG_W-1:0] s);
        logic [COEF_W-1:0] v;
        case (s)
            3'd0:    v = leaded ? 13'd6200 : 13'd5930;
            3'd1:    v = leaded ? 13'd3100 : 13'd2910;
            3'd2:    v = leaded ? 13'd1530 : 13'd1800;
            3'd3:    v = leaded ? 13'd112  : 13'd260;
            default: v = '0;
        endcase
        return v;
    endfunction

    // x^1.4 table entry in Q0.16, evaluated at elaboration
    function automatic logic [POW_W-1:0] pow_entry(input int unsigned idx, input int unsigned n);
        longint unsigned num, x, rem, lim, lo, hi, mid, m2, p5;
        int b, k;
        num = longint'(idx) << 16;
        x   = 0;
        rem = 0;
        for (b = 31; b >= 0; b--) begin
            rem = (rem << 1) | ((num >> b) & 64'd1);
            x   = x << 1;
            if (rem >= longint'(n)) begin
                rem = rem - longint'(n);
                x   = x | 64'd1;
            end
        end
        lim = (x * x) << 28;
        lo  = 0;
        hi  = 4096;
        // largest q with q^5 <= x^2 * 2^28, i.e. x^0.4 in Q0.12
        for (k = 0; k < 14; k++) begin
            if (lo < hi) begin
                mid = (lo + hi + 64'd1) >> 1;
                m2  = mid * mid;
                p5  = m2 * m2 * mid;
                if (p5 <= lim) begin
                    lo = mid;
                end else begin
                    hi = mid - 64'd1;
                end
            end
        end
        return POW_W'((x * lo) >> 12);
    endfunction

endpackage

// ----- rtl/core/alc_div.sv -----
// Restoring radix-2 divider, one quotient bit per cycle.
// Uses alc_pkg widths.
`timescale 1ns / 1ps

module alc_div
    import alc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [DIV_REM_W-1:0] divisor,
    input  logic [DIV_REM_W-1:0] rem_init,
    input  logic [DIV_SH_W-1:0]  shift_in,
    input  logic [DIV_CNT_W-1:0] count,
    output logic                 busy,
    output logic [DIV_SH_W-1:0]  quot
);

    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_REM_W-1:0] rem_reg, dvs_reg;
    logic [DIV_SH_W-1:0]  sh_reg, q_reg;
    logic [DIV_REM_W:0]   trial;
    logic                 ge;

    assign trial = {rem_reg, sh_reg[DIV_SH_W-1]};
    assign ge    = trial >= {1'b0, dvs_reg};
    assign busy  = cnt_reg != '0;
    assign quot  = q_reg;

    always_comb begin
        cnt_next = cnt_reg;
        if (start) begin
            cnt_next = count;
        end else if (busy) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= rem_init;
            sh_reg  <= shift_in;
            dvs_reg <= divisor;
            q_reg   <= '0;
        end else if (busy) begin
            rem_reg <= ge ? DIV_REM_W'(trial - {1'b0, dvs_reg}) : trial[DIV_REM_W-1:0];
            sh_reg  <= {sh_reg[DIV_SH_W-2:0], 1'b0};
            q_reg   <= {q_reg[DIV_SH_W-2:0], ge};
        end
    end

endmodule

// ----- rtl/core/alc_dp.sv -----
// Lux datapath: operand capture, segment select, shared multiplier,
// power table, ratio divider and lux scaler. Depends on alc_pkg and alc_div.
`timescale 1ns / 1ps

module alc_dp
    import alc_pkg::*;
#(
    parameter int POWER_TABLE_ENTRIES = ALC_POW_ENTRIES,
    parameter int RATIO_FRACTION_BITS = ALC_RATIO_FRAC
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  alc_cmd_t         cmd,
    output alc_sts_t         sts,
    input  logic [PKG_W-1:0] package_code,
    input  logic [CNT_W-1:0] broadband_count,
    input  logic [CNT_W-1:0] infrared_count,
    output logic [LUX_W-1:0] lux_value,
    output logic [STS_W-1:0] result_status
);

    localparam int N  = POWER_TABLE_ENTRIES;
    localparam int RF = RATIO_FRACTION_BITS;
    localparam int IW = $clog2(N);
    localparam int PW = RF + IW + 1;

    logic [CNT_W-1:0]   ch0_reg, ch1_reg;
    logic               leaded_reg, pkg_bad_reg, ch0_zero_reg;
    logic [SEG_W-1:0]   seg_reg, seg_next;
    logic [PROD_W-1:0]  prod_reg;
    logic [POS_W-1:0]   pos_reg;
    logic [NEG_W-1:0]   neg_reg;
    logic [IW-1:0]      idx_reg, idx_next;
    logic [POW_W-1:0]   pw_reg;
    logic [LUX_W-1:0]   lux_reg, last_lux_reg;
    logic [STS_W-1:0]   status_reg;

    logic [POW_W-1:0]   pow_tab [N];
    logic [22:0]        ch1_x100;
    logic [23:0]        brk_x_ch0 [4];
    logic [3:0]         hit;
    logic [MUL_A_W-1:0] mul_a;
    logic [CNT_W-1:0]   mul_b;
    logic [COEF_W-1:0]  ka, kb;
    logic [PW-1:0]      idx_sum;
    logic [IW:0]        idx_hi;
    logic               neg_ge;
    logic [POS_W-1:0]   diff;

    logic                 div_start, div_busy;
    logic [DIV_REM_W-1:0] div_dvs, div_rem;
    logic [DIV_SH_W-1:0]  div_sh, div_q;
    logic [DIV_CNT_W-1:0] div_cnt;

    logic [SCL_CNT_W-1:0]   scl_cnt_reg;
    logic [SCL_REM_W-1:0]   scl_rem_reg;
    logic [SCL_NUM_W-1:0]   scl_sh_reg, scl_q_reg;
    logic [SCL_X_W-1:0]     scl_x, scl_r;
    logic [SCL_PROD_W-1:0]  scl_prod;
    logic [SCL_CHUNK_W-1:0] scl_qd;
    logic                   scl_busy;
    logic [LUX_W-1:0]       scl_lux;

    for (genvar g = 0; g < N; g++) begin : g_tab
        assign pow_tab[g] = pow_entry(g, N);
    end

    // breakpoints by cross multiplication: ch1*100 <= T*ch0
    always_comb begin
        ch1_x100 = 23'(ch1_reg) * 23'd100;
        seg_next = 3'd4;
        for (int s = 0; s < 4; s++) begin
            brk_x_ch0[s] = 24'(brk_val(leaded_reg, s)) * 24'(ch0_reg);
            hit[s]       = {1'b0, ch1_x100} <= brk_x_ch0[s];
        end
        for (int s = 3; s >= 0; s--) begin
            if (hit[s]) begin
                seg_next = SEG_W'(s);
            end
        end
    end

    assign ka = coef_a(leaded_reg, seg_reg);
    assign kb = coef_b(leaded_reg, seg_reg);

    always_comb begin
        case (cmd.mul_sel)
            MUL_KA_CH0: begin
                mul_a = MUL_A_W'(ka);
                mul_b = ch0_reg;
            end
            MUL_KB_CH0: begin
                mul_a = MUL_A_W'(kb);
                mul_b = ch0_reg;
            end
            MUL_KB_CH1: begin
                mul_a = MUL_A_W'(kb);
                mul_b = ch1_reg;
            end
            default: begin
                mul_a = prod_reg[MUL_A_W-1:0];
                mul_b = pw_reg;
            end
        endcase
    end

    // table index: round(r*N / 2^RF), limited to the last entry
    always_comb begin
        idx_sum  = PW'(div_q[RF-1:0]) * PW'(N) + (PW'(1) << (RF - 1));
        idx_hi   = idx_sum[PW-1:RF];
        idx_next = (idx_hi > (IW+1)'(N - 1)) ? IW'(N - 1) : idx_hi[IW-1:0];
    end

    assign neg_ge = neg_reg >= {1'b0, pos_reg};
    assign diff   = neg_ge ? '0 : POS_W'({1'b0, pos_reg} - neg_reg);

    // divider forms the table ratio ch1 * 2^RF / ch0
    assign div_start = cmd.div_ratio;
    assign div_dvs   = DIV_REM_W'(ch0_reg);
    assign div_rem   = DIV_REM_W'(ch1_reg);
    assign div_sh    = '0;
    assign div_cnt   = DIV_CNT_W'(RF);

    alc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .divisor  (div_dvs),
        .rem_init (div_rem),
        .shift_in (div_sh),
        .count    (div_cnt),
        .busy     (div_busy),
        .quot     (div_q)
    );

    // lux = floor(diff / 1e5) = floor((diff >> 5) / 3125); each step divides
    // {remainder, next chunk} by 3125 through the reciprocal
    assign scl_busy = scl_cnt_reg != '0;
    assign scl_x    = {scl_rem_reg, scl_sh_reg[SCL_NUM_W-1 -: SCL_CHUNK_W]};
    assign scl_prod = SCL_PROD_W'(scl_x) * SCL_PROD_W'(SCL_RECIP);
    assign scl_qd   = scl_prod[SCL_SHIFT +: SCL_CHUNK_W];
    assign scl_r    = scl_x - SCL_X_W'(scl_qd) * SCL_X_W'(SCL_DIVISOR);
    assign scl_lux  = (|scl_q_reg[SCL_NUM_W-1:LUX_W]) ? '1 : scl_q_reg[LUX_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scl_cnt_reg <= '0;
        end else if (cmd.div_lux) begin
            scl_cnt_reg <= SCL_CNT_W'(SCL_STEPS);
        end else if (scl_busy) begin
            scl_cnt_reg <= scl_cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_lux) begin
            scl_rem_reg <= '0;
            scl_sh_reg  <= diff[POS_W-1:SCL_PRE];
            scl_q_reg   <= '0;
        end else if (scl_busy) begin
            scl_rem_reg <= scl_r[SCL_REM_W-1:0];
            scl_sh_reg  <= scl_sh_reg << SCL_CHUNK_W;
            scl_q_reg   <= {scl_q_reg[SCL_NUM_W-SCL_CHUNK_W-1:0], scl_qd};
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            ch0_reg      <= broadband_count;
            ch1_reg      <= infrared_count;
            ch0_zero_reg <= broadband_count == '0;
            leaded_reg   <= package_code inside {PKG_LD_A, PKG_LD_B};
            pkg_bad_reg  <= !(package_code inside {PKG_CS_A, PKG_CS_B, PKG_LD_A, PKG_LD_B});
        end
        if (cmd.classify) begin
            seg_reg <= seg_next;
        end
        if (cmd.mul_en) begin
            prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
        end
        if (cmd.pos_cap) begin
            pos_reg <= {prod_reg[POS_W-Q_FRAC-1:0], {Q_FRAC{1'b0}}};
        end
        if (cmd.neg_cap) begin
            neg_reg <= cmd.neg_lin ? {prod_reg[NEG_W-Q_FRAC-1:0], {Q_FRAC{1'b0}}}
                                   : prod_reg[NEG_W-1:0];
        end
        if (cmd.idx_cap) begin
            idx_reg <= idx_next;
        end
        if (cmd.tab_cap) begin
            pw_reg <= pow_tab[idx_reg];
        end
        if (cmd.out_load) begin
            case (cmd.out_kind)
                OUT_ZERO: begin
                    lux_reg    <= '0;
                    status_reg <= ST_ZERO;
                end
                OUT_HOLD: begin
                    lux_reg    <= last_lux_reg;
                    status_reg <= ST_BADPKG;
                end
                default: begin
                    lux_reg    <= scl_lux;
                    status_reg <= ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_lux_reg <= '0;
        end else if (cmd.out_load) begin
            case (cmd.out_kind)
                OUT_ZERO: last_lux_reg <= '0;
                OUT_HOLD: last_lux_reg <= last_lux_reg;
                default:  last_lux_reg <= scl_lux;
            endcase
        end
    end

    assign sts.ch0_zero = ch0_zero_reg;
    assign sts.pkg_bad  = pkg_bad_reg;
    assign sts.seg_zero = seg_reg == '0;
    assign sts.div_busy = div_busy | scl_busy;

    assign lux_value     = lux_reg;
    assign result_status = status_reg;

endmodule

// ----- rtl/core/alc_ctrl.sv -----
// Sequencer for the lux datapath and the result beat handshake.
// Depends on alc_pkg.
`timescale 1ns / 1ps

module alc_ctrl
    import alc_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    input  alc_sts_t sts,
    output alc_cmd_t cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CLASS = 4'd1;
    localparam logic [3:0] S_MPOS  = 4'd2;
    localparam logic [3:0] S_MNEG  = 4'd3;
    localparam logic [3:0] S_NEGL  = 4'd4;
    localparam logic [3:0] S_RDIV  = 4'd5;
    localparam logic [3:0] S_IDX   = 4'd6;
    localparam logic [3:0] S_TAB   = 4'd7;
    localparam logic [3:0] S_MP    = 4'd8;
    localparam logic [3:0] S_NEGP  = 4'd9;
    localparam logic [3:0] S_DIFF  = 4'd10;
    localparam logic [3:0] S_LDIV  = 4'd11;
    localparam logic [3:0] S_OUT   = 4'd12;

    logic [3:0] state_reg, state_next;
    logic [1:0] kind_reg, kind_next;
    logic       out_valid_reg, out_valid_next;

    always_comb begin
        state_next = state_reg;
        kind_next  = kind_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_CLASS;
                end
            end
            S_CLASS: begin
                cmd.classify = 1'b1;
                // zero broadband wins over a bad package code
                if (sts.ch0_zero) begin
                    kind_next  = OUT_ZERO;
                    state_next = S_OUT;
                end else if (sts.pkg_bad) begin
                    kind_next  = OUT_HOLD;
                    state_next = S_OUT;
                end else begin
                    state_next = S_MPOS;
                end
            end
            S_MPOS: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_KA_CH0;
                state_next  = S_MNEG;
            end
            S_MNEG: begin
                cmd.pos_cap = 1'b1;
                cmd.mul_en  = 1'b1;
                if (sts.seg_zero) begin
                    cmd.mul_sel   = MUL_KB_CH0;
                    cmd.div_ratio = 1'b1;
                    state_next    = S_RDIV;
                end else begin
                    cmd.mul_sel = MUL_KB_CH1;
                    state_next  = S_NEGL;
                end
            end
            S_NEGL: begin
                cmd.neg_cap = 1'b1;
                cmd.neg_lin = 1'b1;
                state_next  = S_DIFF;
            end
            S_RDIV: begin
                if (!sts.div_busy) begin
                    state_next = S_IDX;
                end
            end
            S_IDX: begin
                cmd.idx_cap = 1'b1;
                state_next  = S_TAB;
            end
            S_TAB: begin
                cmd.tab_cap = 1'b1;
                state_next  = S_MP;
            end
            S_MP: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_PROD_PW;
                state_next  = S_NEGP;
            end
            S_NEGP: begin
                cmd.neg_cap = 1'b1;
                state_next  = S_DIFF;
            end
            S_DIFF: begin
                cmd.div_lux = 1'b1;
                state_next  = S_LDIV;
            end
            S_LDIV: begin
                if (!sts.div_busy) begin
                    kind_next  = OUT_CALC;
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (!out_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
        cmd.out_kind = kind_reg;
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            kind_reg      <= OUT_CALC;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            kind_reg      <= kind_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_ready = state_reg == S_IDLE;
    assign m_valid = out_valid_reg;

endmodule

// ----- rtl/core/ambient_light_lux_calc_unit.sv -----
// Ambient light lux unit top: APB register, sequencer and datapath.
// Zero broadband or a bad package goes straight to the result; linear segments
//   take multiply and scale steps; the lowest adds ratio divide and table lookup.
// One beat in flight; the next input is taken in the cycle after the result loads;
//   a result waits to load while the last one is still pending and m_ready is low.
// Reset (aresetn low, synchronous): package code 1, last lux 0, no result pending.
`timescale 1ns / 1ps
`include "ambient_light_lux_calc_unit_assert.svh"

module ambient_light_lux_calc_unit
    import alc_pkg::*;
#(
    parameter int POWER_TABLE_ENTRIES = ALC_POW_ENTRIES,
    parameter int RATIO_FRACTION_BITS = ALC_RATIO_FRAC
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [CNT_W-1:0] s_broadband_count,
    input  logic [CNT_W-1:0] s_infrared_count,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [LUX_W-1:0] m_lux_value,
    output logic [STS_W-1:0] m_result_status
);

    logic [PKG_W-1:0] pkg_code_reg;
    logic             cfg_wr;
    alc_cmd_t         cmd;
    alc_sts_t         sts;

    assign pready = 1'b1;
    // only word 0 holds a register; paddr[2] set is past the map
    assign cfg_wr = psel && penable && pwrite && pready && !paddr[2];
    assign prdata = paddr[2] ? '0 : 32'(pkg_code_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pkg_code_reg <= PKG_RESET;
        end else if (cfg_wr) begin
            pkg_code_reg <= pwdata[PKG_W-1:0];
        end
    end

    alc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    alc_dp #(
        .POWER_TABLE_ENTRIES (POWER_TABLE_ENTRIES),
        .RATIO_FRACTION_BITS (RATIO_FRACTION_BITS)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .sts             (sts),
        .package_code    (pkg_code_reg),
        .broadband_count (s_broadband_count),
        .infrared_count  (s_infrared_count),
        .lux_value       (m_lux_value),
        .result_status   (m_result_status)
    );

    `ALC_CHK_NEXT(a_busy_after_accept, s_valid && s_ready, !s_ready)
    `ALC_CHK_IMPL(a_zero_status_lux, m_valid && m_result_status == ST_ZERO, m_lux_value == '0)
    `ALC_CHK_NEXT(a_load_shows_valid, cmd.out_load, m_valid)
    `ALC_CHK_IMPL(a_div_start_idle, cmd.div_ratio || cmd.div_lux, !sts.div_busy)

endmodule
